@@ hdl/gsa_pkg.sv @@
`default_nettype none

package gsa_pkg;

  // Pool geometry: slot index is (column << ROW_BITS) | row.
  localparam int COL_BITS   = 4;
  localparam int ROW_BITS   = 4;
  localparam int GEN_BITS   = 8;
  localparam int SLOT_BITS  = COL_BITS + ROW_BITS;
  localparam int SLOT_COUNT = 1 << SLOT_BITS;

  // The free search splits the slot index into a group part and a lane part.
  localparam int GRP_BITS   = SLOT_BITS / 2;
  localparam int LANE_BITS  = SLOT_BITS - GRP_BITS;
  localparam int GRP_COUNT  = 1 << GRP_BITS;
  localparam int LANE_COUNT = 1 << LANE_BITS;

  localparam int HANDLE_BITS = 16;
  localparam int TILE_BITS   = 12;
  localparam int SIZE_BITS   = 8;
  localparam int PIX_BITS    = 20;
  localparam int TYPE_BITS   = 16;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_FREE   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic {
    REG_PX_PER_COL = 1'b0,
    REG_PX_PER_ROW = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [1:0]             action;
    logic [HANDLE_BITS-1:0] handle;
    logic [TILE_BITS-1:0]   tile_x;
    logic [TILE_BITS-1:0]   tile_y;
    logic [TYPE_BITS-1:0]   type_id;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] handle_out;
    logic [TYPE_BITS-1:0]   type_out;
    logic [PIX_BITS-1:0]    pix_x;
    logic [PIX_BITS-1:0]    pix_y;
  } rsp_t;

  // One slot entry as it lies in the slot memory.
  typedef struct packed {
    logic [GEN_BITS-1:0]  gen;
    logic [TYPE_BITS-1:0] type_id;
    logic [PIX_BITS-1:0]  pix_x;
    logic [PIX_BITS-1:0]  pix_y;
  } slot_t;

  // Handle is generation above the slot index, kept to its low 16 bits.
  function automatic logic [HANDLE_BITS-1:0] pack_handle(logic [GEN_BITS-1:0] gen,
                                                         logic [SLOT_BITS-1:0] slot);
    logic [31:0] wide;
    wide = (32'(gen) << SLOT_BITS) | 32'(slot);
    return wide[HANDLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/generational_slot_allocator.sv @@
`default_nettype none

// Generational slot allocator.
// A request is taken on the rising edge where start is high and busy is low.
// It carries an action (allocate, lookup, free), a handle and, for allocate,
// a tile position and a type id. Each request gives exactly one response on
// rsp, marked by done for a single cycle; the receiver cannot stall, so the
// response must be captured in that cycle.
// A request passes the accept state S_IDLE, then S_ISSUE, which reads the slot
// memory and picks the lowest non-full group of slots, then S_SELECT, which
// picks the free slot inside that group and checks the stored generation,
// then S_WRITE, which writes back and registers the response. done rises in
// the cycle after that, which is also the first cycle a new request is
// accepted; no new request is taken before the last is answered. These steps
// follow the single-port-per-direction slot memory and two-level free search.
// The tile size registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high.
// Reset clears the occupancy bits (the whole pool is free at once, no clearing
// pass), the generation counter and restores tile sizes of 16 pixels.
module generational_slot_allocator
  import gsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire req_t                 req,
  output logic                      done,
  output rsp_t                      rsp,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [SIZE_BITS-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_SELECT,
    S_WRITE
  } state_t;

  state_t                state;
  req_t                  req_q;
  logic [SIZE_BITS-1:0]  px_per_col;
  logic [SIZE_BITS-1:0]  px_per_row;
  logic [PIX_BITS-1:0]   prod_x;
  logic [PIX_BITS-1:0]   prod_y;
  logic [GRP_BITS-1:0]   grp_q;
  logic                  pool_full;
  logic [SLOT_BITS-1:0]  slot_q;
  logic                  hit;
  logic [GEN_BITS-1:0]   gen_counter;
  logic [SLOT_COUNT-1:0] occupied;

  logic [GEN_BITS-1:0]   gen_next;
  logic [GRP_COUNT-1:0]  group_full;
  logic [GRP_BITS-1:0]   free_grp;
  logic [LANE_COUNT-1:0] grp_lanes;
  logic [LANE_BITS-1:0]  free_lane;
  logic [SLOT_BITS-1:0]  lookup_slot;
  logic                  hit_next;
  slot_t                 rd_entry;
  slot_t                 wr_entry;
  rsp_t                  rsp_next;
  logic                  ram_we;
  logic                  ram_re;
  logic                  is_alloc;
  logic                  is_check;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign is_alloc    = (req_q.action == ACT_ALLOC);
  assign is_check    = (req_q.action == ACT_LOOKUP) || (req_q.action == ACT_FREE);
  assign lookup_slot = req_q.handle[SLOT_BITS-1:0];

  // Generation counter advance: wraps and skips zero.
  always_comb begin
    gen_next = gen_counter + 1'b1;
    if (gen_next == '0) begin
      gen_next = {{(GEN_BITS-1){1'b0}}, 1'b1};
    end
  end

  // First level of the free search: lowest group with a free slot.
  always_comb begin
    free_grp = '0;
    for (int g = 0; g < GRP_COUNT; g++) begin
      group_full[g] = &occupied[g*LANE_COUNT +: LANE_COUNT];
    end
    for (int g = GRP_COUNT - 1; g >= 0; g--) begin
      if (!group_full[g]) begin
        free_grp = GRP_BITS'(g);
      end
    end
  end

  // Second level: lowest free lane inside the chosen group.
  always_comb begin
    free_lane = '0;
    grp_lanes = occupied[{grp_q, {LANE_BITS{1'b0}}} +: LANE_COUNT];
    for (int l = LANE_COUNT - 1; l >= 0; l--) begin
      if (!grp_lanes[l]) begin
        free_lane = LANE_BITS'(l);
      end
    end
  end

  // Handle check against the entry read in the previous cycle.
  assign hit_next = is_check && occupied[lookup_slot]
                    && (pack_handle(rd_entry.gen, lookup_slot) == req_q.handle);

  // Slot memory access: read the handle's slot, write a new allocation.
  assign ram_re = (state == S_ISSUE);
  assign ram_we = (state == S_WRITE) && is_alloc && !pool_full;

  always_comb begin
    wr_entry.gen     = gen_next;
    wr_entry.type_id = req_q.type_id;
    wr_entry.pix_x   = prod_x;
    wr_entry.pix_y   = prod_y;
  end

  gsa_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_q),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (lookup_slot),
    .rdata (rd_entry)
  );

  // Response for the request in its write-back cycle.
  always_comb begin
    rsp_next = '0;
    if (is_alloc) begin
      if (pool_full) begin
        rsp_next.status = ST_FULL;
      end else begin
        rsp_next.status     = ST_OK;
        rsp_next.handle_out = pack_handle(gen_next, slot_q);
        rsp_next.type_out   = req_q.type_id;
        rsp_next.pix_x      = prod_x;
        rsp_next.pix_y      = prod_y;
      end
    end else if (hit) begin
      rsp_next.status     = ST_OK;
      rsp_next.handle_out = req_q.handle;
      rsp_next.type_out   = rd_entry.type_id;
      rsp_next.pix_x      = rd_entry.pix_x;
      rsp_next.pix_y      = rd_entry.pix_y;
    end else begin
      rsp_next.status = ST_MISS;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      px_per_col <= SIZE_BITS'(16);
      px_per_row <= SIZE_BITS'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PX_PER_COL: px_per_col <= cfg_data;
        REG_PX_PER_ROW: px_per_row <= cfg_data;
        default:        px_per_col <= px_per_col;
      endcase
    end
  end

  // Request datapath registers.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    if (state == S_ISSUE) begin
      prod_x    <= PIX_BITS'(req_q.tile_x) * PIX_BITS'(px_per_col);
      prod_y    <= PIX_BITS'(req_q.tile_y) * PIX_BITS'(px_per_row);
      grp_q     <= free_grp;
      pool_full <= &group_full;
    end
    if (state == S_SELECT) begin
      slot_q <= {grp_q, free_lane};
      hit    <= hit_next;
    end
  end

  // Sequencer, occupancy, generation counter and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      gen_counter <= '0;
      occupied    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_SELECT;
        end
        S_SELECT: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_IDLE;
          done  <= 1'b1;
          rsp   <= rsp_next;
          if (is_alloc) begin
            if (!pool_full) begin
              gen_counter      <= gen_next;
              occupied[slot_q] <= 1'b1;
            end
          end else if (hit && req_q.action == ACT_FREE) begin
            occupied[lookup_slot] <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A response only follows the write-back cycle.
  a_done_after_write: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_WRITE))
    else $error("response strobe without a finished request");

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  // A successful allocation marks its slot occupied.
  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && is_alloc && !pool_full) |=> occupied[$past(slot_q)])
    else $error("allocated slot not marked occupied");

  // A successful free releases its slot.
  a_free_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && req_q.action == ACT_FREE && hit)
      |=> !occupied[$past(lookup_slot)])
    else $error("freed slot still marked occupied");

  // The search never hands out a slot that is already taken.
  a_alloc_free_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && is_alloc && !pool_full) |-> !occupied[slot_q])
    else $error("allocation picked an occupied slot");
`endif

endmodule

`default_nettype wire

@@ hdl/gsa_ram.sv @@
`default_nettype none

module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ verif/gsa_slot_checker.sv @@
`timescale 1ns / 1ps

// Watches the request, response and register channels of the slot allocator,
// keeps its own copy of the slot pool and checks each response in order.
module gsa_slot_checker
  import gsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  req_t                 req,
  input  logic                 done,
  input  rsp_t                 rsp,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_data,
  output int                   fail_count,
  output int                   waiting
);

  // Shadow copy of the slot pool and the tile size registers.
  logic [GEN_BITS-1:0]  pool_gen   [SLOT_COUNT];
  logic [TYPE_BITS-1:0] pool_kind  [SLOT_COUNT];
  logic [PIX_BITS-1:0]  pool_px    [SLOT_COUNT];
  logic [PIX_BITS-1:0]  pool_py    [SLOT_COUNT];
  logic [GEN_BITS-1:0]  gen_ctr;
  logic [SIZE_BITS-1:0] tile_w;
  logic [SIZE_BITS-1:0] tile_h;

  // Responses owed by the block, oldest first.
  rsp_t owed_responses[$];

  // Applies one request to the shadow pool and returns the response it owes.
  task automatic serve_request(input req_t r, output rsp_t o);
    logic                 found;
    logic [SLOT_BITS-1:0] idx;
    logic [31:0]          wide;
    logic [31:0]          px_full;
    logic [31:0]          py_full;
    o = '0;
    found = 1'b0;
    idx = '0;
    case (r.action)
      ACT_ALLOC: begin
        // Lowest free slot wins.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!found && pool_gen[i] == '0) begin
            found = 1'b1;
            idx = SLOT_BITS'(i);
          end
        end
        if (!found) begin
          o.status = ST_FULL;
        end else begin
          // The generation wraps and never takes the value zero.
          gen_ctr = gen_ctr + 1'b1;
          if (gen_ctr == '0) begin
            gen_ctr = GEN_BITS'(1);
          end
          px_full = 32'(r.tile_x) * 32'(tile_w);
          py_full = 32'(r.tile_y) * 32'(tile_h);
          pool_gen[idx] = gen_ctr;
          pool_kind[idx] = r.type_id;
          pool_px[idx] = px_full[PIX_BITS-1:0];
          pool_py[idx] = py_full[PIX_BITS-1:0];
          wide = (32'(gen_ctr) << SLOT_BITS) | 32'(idx);
          o.status = ST_OK;
          o.handle_out = wide[HANDLE_BITS-1:0];
          o.type_out = r.type_id;
          o.pix_x = px_full[PIX_BITS-1:0];
          o.pix_y = py_full[PIX_BITS-1:0];
        end
      end
      ACT_LOOKUP, ACT_FREE: begin
        idx = r.handle[SLOT_BITS-1:0];
        wide = (32'(pool_gen[idx]) << SLOT_BITS) | 32'(idx);
        if (pool_gen[idx] != '0 && wide[HANDLE_BITS-1:0] == r.handle) begin
          o.status = ST_OK;
          o.handle_out = r.handle;
          o.type_out = pool_kind[idx];
          o.pix_x = pool_px[idx];
          o.pix_y = pool_py[idx];
          if (r.action == ACT_FREE) begin
            pool_gen[idx] = '0;
            pool_kind[idx] = '0;
            pool_px[idx] = '0;
            pool_py[idx] = '0;
          end
        end else begin
          o.status = ST_MISS;
        end
      end
      default: begin
        o.status = ST_MISS;
      end
    endcase
  endtask

  // Compares one response field and reports a difference.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Sample every channel at the rising edge, retire responses before taking
  // a new request, since both can happen at the same edge.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        pool_gen[i] = '0;
        pool_kind[i] = '0;
        pool_px[i] = '0;
        pool_py[i] = '0;
      end
      gen_ctr = '0;
      tile_w = SIZE_BITS'(16);
      tile_h = SIZE_BITS'(16);
      owed_responses.delete();
      waiting <= 0;
    end else begin
      if (done) begin
        if (owed_responses.size() == 0) begin
          $display("%0t: unexpected response: expected none, actual %0h", $time, rsp);
          fail_count++;
        end else begin
          want = owed_responses.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("handle_out", 32'(want.handle_out), 32'(rsp.handle_out));
          check_field("type_out", 32'(want.type_out), 32'(rsp.type_out));
          check_field("pix_x", 32'(want.pix_x), 32'(rsp.pix_x));
          check_field("pix_y", 32'(want.pix_y), 32'(rsp.pix_y));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PX_PER_COL: tile_w = cfg_data;
          REG_PX_PER_ROW: tile_h = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        serve_request(req, want);
        owed_responses.push_back(want);
      end
      waiting <= owed_responses.size();
    end
  end

endmodule

@@ verif/tb_generational_slot_allocator.sv @@
`timescale 1ns / 1ps

module tb_generational_slot_allocator;
  import gsa_pkg::*;

  // Action code that the block has no meaning for.
  localparam logic [1:0] ACT_UNDEFINED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int HANDLE_MEMORY = 64;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  req_t                 req;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_index;
  logic [SIZE_BITS-1:0] cfg_data;
  int                   fail_count;
  int                   waiting;
  int                   idle_cycles = 0;

  // Handles recently handed back by the block; some are live, some stale.
  logic [HANDLE_BITS-1:0] recent_handles[$];

  generational_slot_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gsa_slot_checker slot_watch (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Remember handles from successful responses for later lookups and frees.
  always @(posedge clk) begin
    if (!rst && done && rsp.status == ST_OK) begin
      recent_handles.push_back(rsp.handle_out);
      if (recent_handles.size() > HANDLE_MEMORY) begin
        void'(recent_handles.pop_front());
      end
    end
  end

  // End the run when nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("generational_slot_allocator regression: fail");
      $finish;
    end
  end

  // Holds a request on the port until the block takes it.
  task automatic send_request(input req_t r);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
  endtask

  // Drops start for a gap given by n; zero keeps it high for back-to-back requests.
  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Waits until every request has its response and the block is idle.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (waiting != 0 || busy);
  endtask

  // Writes both tile size registers, keeping valid high across the pair.
  task automatic set_tile_size(input logic [SIZE_BITS-1:0] w,
                               input logic [SIZE_BITS-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PX_PER_COL;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_PX_PER_ROW;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.action = 2'($urandom_range(0, 3));
    r.handle = HANDLE_BITS'($urandom_range(0, 65535));
    r.tile_x = TILE_BITS'($urandom_range(0, 4095));
    r.tile_y = TILE_BITS'($urandom_range(0, 4095));
    r.type_id = TYPE_BITS'($urandom_range(0, 65535));
    return r;
  endfunction

  // Tile coordinates lean toward the ends of their range.
  function automatic logic [TILE_BITS-1:0] tile_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 30) return '1;
    return TILE_BITS'($urandom_range(0, 4095));
  endfunction

  // A remembered handle, one with a disturbed generation, or pure noise.
  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    int roll;
    logic [HANDLE_BITS-1:0] h;
    roll = $urandom_range(0, 99);
    if (recent_handles.size() == 0 || roll < 15) begin
      return HANDLE_BITS'($urandom_range(0, 65535));
    end
    h = recent_handles[$urandom_range(0, recent_handles.size() - 1)];
    if (roll < 25) begin
      h = h ^ (HANDLE_BITS'(1) << (SLOT_BITS + $urandom_range(0, GEN_BITS - 1)));
    end
    return h;
  endfunction

  function automatic req_t alloc_req(input logic [TILE_BITS-1:0] x,
                                     input logic [TILE_BITS-1:0] y,
                                     input logic [TYPE_BITS-1:0] kind);
    req_t r;
    r = random_request();
    r.action = ACT_ALLOC;
    r.tile_x = x;
    r.tile_y = y;
    r.type_id = kind;
    return r;
  endfunction

  function automatic req_t handle_req(input logic [1:0] act,
                                      input logic [HANDLE_BITS-1:0] h);
    req_t r;
    r = random_request();
    r.action = act;
    r.handle = h;
    return r;
  endfunction

  // Random traffic with the given share of allocations and lookups; the
  // rest is frees plus a little undefined traffic.
  task automatic run_phase(input int count, input int alloc_pct, input int lookup_pct);
    int  roll;
    bit  burst;
    req_t r;
    burst = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        r = alloc_req(tile_coord(), tile_coord(), TYPE_BITS'($urandom_range(0, 65535)));
      end else if (roll < alloc_pct + lookup_pct) begin
        r = handle_req(ACT_LOOKUP, pick_handle());
      end else if (roll < 98) begin
        r = handle_req(ACT_FREE, pick_handle());
      end else begin
        r = handle_req(ACT_UNDEFINED, pick_handle());
      end
      send_request(r);
      if ($urandom_range(0, 49) == 0) begin
        settle();
      end else if (!burst) begin
        pause(pick_gap());
      end
    end
  endtask

  initial begin
    logic [HANDLE_BITS-1:0] h_first;
    logic [HANDLE_BITS-1:0] h_second;
    logic [HANDLE_BITS-1:0] h_third;
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PX_PER_COL;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty pool at reset tile sizes: the zero handle, free of a free slot,
    // undefined action, then allocations at two corners of the tile range and one inside it.
    send_request(handle_req(ACT_LOOKUP, '0));
    send_request(handle_req(ACT_FREE, '0));
    send_request(handle_req(ACT_UNDEFINED, 16'hFFFF));
    send_request(alloc_req('0, '0, '0));
    send_request(alloc_req('1, '1, 16'hFFFF));
    pause(2);
    send_request(alloc_req(12'd1, 12'd2, 16'h1234));
    settle();
    h_first = recent_handles[0];
    h_second = recent_handles[1];
    h_third = recent_handles[2];

    // Lookups with good, stale-generation, zero-generation and free-slot handles,
    // then a free that reports contents and leaves the handle dead.
    send_request(handle_req(ACT_LOOKUP, h_first));
    send_request(handle_req(ACT_LOOKUP, h_second ^ 16'h0100));
    send_request(handle_req(ACT_LOOKUP, h_first & 16'h00FF));
    send_request(handle_req(ACT_LOOKUP, 16'hFFFF));
    pause(1);
    send_request(handle_req(ACT_FREE, h_second));
    send_request(handle_req(ACT_LOOKUP, h_second));
    send_request(handle_req(ACT_FREE, h_second));
    // The freed slot is the lowest free one and gets reused.
    send_request(alloc_req('1, '0, 16'h8000));
    send_request(alloc_req('0, '1, 16'h0001));
    settle();
    send_request(handle_req(ACT_FREE, h_first));
    send_request(handle_req(ACT_FREE, h_third));
    send_request(handle_req(ACT_LOOKUP, recent_handles[$]));
    send_request(handle_req(ACT_UNDEFINED, h_first));
    settle();

    // Random phases over several tile sizes, the extremes and zero among them.
    set_tile_size(8'd255, 8'd255);
    run_phase(150, 45, 25);
    settle();
    // Allocation heavy: fills the pool and wraps the generation counter.
    set_tile_size(8'd1, 8'd1);
    run_phase(300, 88, 7);
    settle();
    set_tile_size(8'd0, 8'd255);
    run_phase(150, 20, 25);
    settle();
    set_tile_size(8'd255, 8'd0);
    run_phase(100, 45, 25);
    settle();
    set_tile_size(SIZE_BITS'($urandom_range(1, 255)), SIZE_BITS'($urandom_range(1, 255)));
    run_phase(100, 45, 25);
    settle();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("generational_slot_allocator regression: pass");
    end else begin
      $display("generational_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/gsa_pkg.sv
hdl/gsa_ram.sv
hdl/generational_slot_allocator.sv
verif/gsa_slot_checker.sv
verif/tb_generational_slot_allocator.sv
